FILE: hdl/trm_pkg.sv
// trm_pkg: shared types and constants for the two-run merge unit.
// No dependencies; used by every other file of the block except trm_ram.
`timescale 1ns / 1ps

package trm_pkg;

    localparam int RUN_DEPTH    = 256;
    localparam int TAG_BITS     = 32;

    localparam int KEY_BITS     = 16;
    localparam int CMD_BITS     = 2;
    localparam int OUT_TAG_BITS = 32;

    // pointer holds 0..RUN_DEPTH, address holds 0..RUN_DEPTH-1
    localparam int PTR_W        = $clog2(RUN_DEPTH + 1);
    localparam int ADDR_W       = $clog2(RUN_DEPTH);
    localparam int TAG_WIDE     = (TAG_BITS > OUT_TAG_BITS) ? TAG_BITS : OUT_TAG_BITS;
    localparam int ENTRY_BITS   = KEY_BITS + TAG_BITS;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_PUSH_A = 2'd0,
        CMD_PUSH_B = 2'd1,
        CMD_PULL   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_run_ctrl;

    typedef struct packed {
        logic   full;
        logic   nonempty;
        logic   one_left;
        t_entry head;
    } t_run_stat;

    typedef struct packed {
        logic [KEY_BITS-1:0]     out_key;
        logic [OUT_TAG_BITS-1:0] out_tag;
        logic                    from_run_b;
        logic                    empty_res;
        logic                    last;
        logic                    overflow;
    } t_result;

endpackage

FILE: hdl/trm_if.sv
// Handshake channels of the two-run merge unit: command in, result out.
// Depends on trm_pkg for field widths.
`timescale 1ns / 1ps

interface trm_in_if;
    logic                          valid;
    logic                          ready;
    logic [trm_pkg::CMD_BITS-1:0]  cmd;
    logic [trm_pkg::KEY_BITS-1:0]  weight_key;
    logic [31:0]                   record_tag;

    modport source (output valid, output cmd, output weight_key, output record_tag,
                    input ready);
    modport sink   (input valid, input cmd, input weight_key, input record_tag,
                    output ready);
endinterface

interface trm_out_if;
    logic                              valid;
    logic                              ready;
    logic [trm_pkg::KEY_BITS-1:0]      out_key;
    logic [trm_pkg::OUT_TAG_BITS-1:0]  out_tag;
    logic                              from_run_b;
    logic                              empty_res;
    logic                              last;
    logic                              overflow;

    modport source (output valid, output out_key, output out_tag, output from_run_b,
                    output empty_res, output last, output overflow, input ready);
    modport sink   (input valid, input out_key, input out_tag, input from_run_b,
                    input empty_res, input last, input overflow, output ready);
endinterface

FILE: hdl/two_run_merge_unit.sv
// two_run_merge_unit: stable merge of two descending runs, top level.
// Depends on trm_pkg, trm_if, trm_run (with trm_ram) and trm_skid.
`timescale 1ns / 1ps

// The unit takes one command beat per clock and answers a pull or an
// overflowing push with one result beat; plain pushes, zero-weight pushes
// and clears give no result. Each run lives in its own RAM of RUN_DEPTH
// entries; the head entry of each run is prefetched into the RAM read
// register (the read address follows the next head pointer), so a pull
// needs only one 16-bit compare of the two heads and finishes in the cycle
// it is accepted. Throughput is one beat per cycle while ready is high, limited
// by the single write and single read port of each run RAM. Results go through
// a two-slot output register, so the input keeps taking beats while a result
// waits; ready drops only while both slots are held. On equal weights run A
// wins. A run takes at most RUN_DEPTH pushes between clears; further
// nonzero pushes return overflow. No clearing pass is needed after reset.

module two_run_merge_unit (
    input  logic  i_clk,
    input  logic  i_rst_n,
    trm_in_if.sink    i_in,
    trm_out_if.source o_out
);

    trm_pkg::t_cmd      w_cmd;
    logic               w_accept;
    logic               w_core_ready;
    logic               w_key_nz;
    logic               w_take_b;
    logic               w_res_valid;
    trm_pkg::t_result   w_res;
    trm_pkg::t_result   w_out;
    trm_pkg::t_run_ctrl w_ctrl_a, w_ctrl_b;
    trm_pkg::t_run_stat w_stat_a, w_stat_b;
    trm_pkg::t_entry    w_wdata;
    trm_pkg::t_entry    w_src;
    logic [trm_pkg::TAG_WIDE-1:0] w_tag_wide;

    assign w_cmd    = trm_pkg::t_cmd'(i_in.cmd);
    assign w_accept = i_in.valid && w_core_ready;
    assign w_key_nz = (i_in.weight_key != '0);

    assign i_in.ready  = w_core_ready;
    assign w_wdata.key = i_in.weight_key;
    assign w_wdata.tag = i_in.record_tag[trm_pkg::TAG_BITS-1:0];

    // B only when A is drained or B's head is strictly larger
    assign w_take_b = !w_stat_a.nonempty ||
                      (w_stat_b.nonempty && (w_stat_a.head.key < w_stat_b.head.key));
    assign w_src      = w_take_b ? w_stat_b.head : w_stat_a.head;
    assign w_tag_wide = trm_pkg::TAG_WIDE'(w_src.tag);

    always_comb begin
        w_ctrl_a    = '0;
        w_ctrl_b    = '0;
        w_res       = '0;
        w_res_valid = 1'b0;
        if (w_accept) begin
            unique case (w_cmd)
                trm_pkg::CMD_PUSH_A: begin
                    if (w_key_nz) begin
                        w_ctrl_a.push = !w_stat_a.full;
                        w_res_valid   = w_stat_a.full;
                        w_res.overflow = 1'b1;
                    end
                end
                trm_pkg::CMD_PUSH_B: begin
                    if (w_key_nz) begin
                        w_ctrl_b.push = !w_stat_b.full;
                        w_res_valid   = w_stat_b.full;
                        w_res.overflow = 1'b1;
                    end
                end
                trm_pkg::CMD_PULL: begin
                    w_res_valid = 1'b1;
                    if (!w_stat_a.nonempty && !w_stat_b.nonempty) begin
                        w_res.empty_res = 1'b1;
                    end else begin
                        w_ctrl_a.pop     = !w_take_b;
                        w_ctrl_b.pop     = w_take_b;
                        w_res.out_key    = w_src.key;
                        w_res.out_tag    = w_tag_wide[trm_pkg::OUT_TAG_BITS-1:0];
                        w_res.from_run_b = w_take_b;
                        // final record: one left in total across both runs
                        w_res.last = (w_stat_a.one_left && !w_stat_b.nonempty) ||
                                     (w_stat_b.one_left && !w_stat_a.nonempty);
                    end
                end
                trm_pkg::CMD_CLEAR: begin
                    w_ctrl_a.clear = 1'b1;
                    w_ctrl_b.clear = 1'b1;
                end
            endcase
        end
    end

    trm_run u_run_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl_a),
        .i_wdata (w_wdata),
        .o_stat  (w_stat_a)
    );

    trm_run u_run_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl_b),
        .i_wdata (w_wdata),
        .o_stat  (w_stat_b)
    );

    trm_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .i_data  (w_res),
        .o_ready (w_core_ready),
        .o_valid (o_out.valid),
        .o_data  (w_out),
        .i_ready (o_out.ready)
    );

    assign o_out.out_key    = w_out.out_key;
    assign o_out.out_tag    = w_out.out_tag;
    assign o_out.from_run_b = w_out.from_run_b;
    assign o_out.empty_res  = w_out.empty_res;
    assign o_out.last       = w_out.last;
    assign o_out.overflow   = w_out.overflow;

endmodule

FILE: hdl/trm_ram.sv
// trm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module trm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/trm_run.sv
// trm_run: one run store with fill and head pointers and a prefetched head entry.
// Depends on trm_pkg and trm_ram.
`timescale 1ns / 1ps

module trm_run (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  trm_pkg::t_run_ctrl i_ctrl,
    input  trm_pkg::t_entry    i_wdata,
    output trm_pkg::t_run_stat o_stat
);

    logic [trm_pkg::PTR_W-1:0]  r_fill, n_fill;
    logic [trm_pkg::PTR_W-1:0]  r_head, n_head;
    logic                       r_byp, n_byp;
    trm_pkg::t_entry            r_byp_data;
    logic [trm_pkg::ADDR_W-1:0] w_raddr;
    logic [trm_pkg::ENTRY_BITS-1:0] w_rdata;

    always_comb begin
        n_fill = r_fill;
        n_head = r_head;
        if (i_ctrl.clear) begin
            n_fill = '0;
            n_head = '0;
        end else begin
            if (i_ctrl.push) n_fill = r_fill + trm_pkg::PTR_W'(1);
            if (i_ctrl.pop)  n_head = r_head + trm_pkg::PTR_W'(1);
        end
        // read the entry that will be the head next cycle
        if (n_head < trm_pkg::PTR_W'(trm_pkg::RUN_DEPTH)) begin
            w_raddr = n_head[trm_pkg::ADDR_W-1:0];
        end else begin
            w_raddr = '0;
        end
        // write lands on the address being read: forward it
        n_byp = i_ctrl.push && (r_fill == n_head);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_head <= '0;
            r_byp  <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_head <= n_head;
            r_byp  <= n_byp;
        end
        r_byp_data <= i_wdata;
    end

    trm_ram #(
        .WIDTH (trm_pkg::ENTRY_BITS),
        .DEPTH (trm_pkg::RUN_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.push),
        .i_waddr (r_fill[trm_pkg::ADDR_W-1:0]),
        .i_wdata (i_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        o_stat.full     = (r_fill == trm_pkg::PTR_W'(trm_pkg::RUN_DEPTH));
        o_stat.nonempty = (r_fill != r_head);
        o_stat.one_left = ((r_fill - r_head) == trm_pkg::PTR_W'(1));
        o_stat.head     = r_byp ? r_byp_data : trm_pkg::t_entry'(w_rdata);
    end

endmodule

FILE: hdl/trm_skid.sv
// trm_skid: two-slot result register (output stage plus skid stage).
// Depends on trm_pkg.
`timescale 1ns / 1ps

module trm_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  trm_pkg::t_result i_data,
    output logic             o_ready,
    output logic             o_valid,
    output trm_pkg::t_result o_data,
    input  logic             i_ready
);

    logic             r_v0, r_v1;
    trm_pkg::t_result r_d0, r_d1;

    // upstream only writes while the skid slot is free
    assign o_ready = !r_v1;
    assign o_valid = r_v0;
    assign o_data  = r_d0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (!r_v0 || i_ready) begin
            if (r_v1) begin
                r_v0 <= 1'b1;
                r_v1 <= 1'b0;
            end else begin
                r_v0 <= i_valid;
            end
        end else if (i_valid) begin
            r_v1 <= 1'b1;
        end

        if (!r_v0 || i_ready) begin
            r_d0 <= r_v1 ? r_d1 : i_data;
        end else if (i_valid) begin
            r_d1 <= i_data;
        end
    end

endmodule
